@@ hdl/cpu_utilization_monitor_core_assert.svh @@
// assertion macros for the cpu utilization monitor
// used by modules that include this header; expects i_clk and i_rst_n in scope
`ifndef CPU_UTILIZATION_MONITOR_CORE_ASSERT_SVH
`define CPU_UTILIZATION_MONITOR_CORE_ASSERT_SVH

// same-cycle implication
`define CPUM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CPUM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/cpum_pkg.sv @@
// shared types and constants for the cpu utilization monitor
// no dependencies
package cpum_pkg;
    localparam int MAX_CPUS   = 64;
    localparam int IDX_W      = 6;
    localparam int CNT_W      = 64;
    localparam int SHARE_W    = 16;
    localparam int PCT_W      = 7;
    localparam int MULT_W     = 17;
    localparam int ENTRY_W    = 3 * CNT_W;
    localparam int RAM_AW     = (MAX_CPUS > 1) ? $clog2(MAX_CPUS) : 1;

    localparam logic [MULT_W-1:0]  MULT_SHARE = MULT_W'(65536);
    localparam logic [MULT_W-1:0]  MULT_PCT   = MULT_W'(100);
    localparam logic [SHARE_W-1:0] SAT_SHARE  = SHARE_W'(65535);
    localparam logic [SHARE_W-1:0] SAT_PCT    = SHARE_W'(100);

    // request to the scaled divider
    typedef struct packed {
        logic [CNT_W-1:0]   a;
        logic               a_carry;
        logic [MULT_W-1:0]  m;
        logic [CNT_W-1:0]   t;
        logic [SHARE_W-1:0] sat;
    } t_div_req;
endpackage

@@ hdl/cpum_ram.sv @@
// generic single-port-write, single-port-read synchronous ram
// registered read data; no dependencies
module cpum_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 192,
    parameter int AW    = 6
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

@@ hdl/cpum_div.sv @@
// bit-serial scaled divider: floor(a*m/t), with zero and saturation cases
// depends on cpum_pkg
module cpum_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  cpum_pkg::t_div_req        i_req,
    output logic                      o_busy,
    output logic                      o_done,
    output logic [cpum_pkg::SHARE_W-1:0] o_q
);
    import cpum_pkg::*;

    logic                r_busy, r_ph, r_done;
    logic [CNT_W-1:0]    r_r, r_a, r_t;
    logic [MULT_W-1:0]   r_q, r_m;
    logic [4:0]          r_bit;
    logic [SHARE_W-1:0]  r_res;

    logic [CNT_W:0]      sh, s;
    logic [CNT_W-1:0]    n_r;
    logic [MULT_W-1:0]   n_q;

    always_comb begin
        sh  = {r_r, 1'b0};
        s   = {1'b0, r_r} + {1'b0, r_a};
        n_r = r_r;
        n_q = r_q;
        if (!r_ph) begin
            if (sh[CNT_W] || sh[CNT_W-1:0] >= r_t) begin
                n_r = sh[CNT_W-1:0] - r_t;
                n_q = {r_q[MULT_W-2:0], 1'b1};
            end else begin
                n_r = sh[CNT_W-1:0];
                n_q = {r_q[MULT_W-2:0], 1'b0};
            end
        end else if (r_m[r_bit]) begin
            if (s[CNT_W] || s[CNT_W-1:0] >= r_t) begin
                n_r = s[CNT_W-1:0] - r_t;
                n_q = r_q + MULT_W'(1);
            end else begin
                n_r = s[CNT_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_ph   <= 1'b0;
        end else begin
            if (i_start && !r_busy) begin
                r_a   <= i_req.a;
                r_t   <= i_req.t;
                r_m   <= i_req.m;
                r_r   <= '0;
                r_q   <= '0;
                r_bit <= 5'(MULT_W - 1);
                r_ph  <= 1'b0;
                if (i_req.t == '0) begin
                    r_res  <= '0;
                    r_done <= 1'b1;
                end else if (i_req.a_carry || i_req.a >= i_req.t) begin
                    r_res  <= i_req.sat;
                    r_done <= 1'b1;
                end else begin
                    r_busy <= 1'b1;
                    r_done <= 1'b0;
                end
            end else if (r_busy) begin
                r_r <= n_r;
                r_q <= n_q;
                r_ph <= !r_ph;
                if (r_ph && r_bit == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                    r_res  <= n_q[SHARE_W-1:0];
                end else begin
                    r_done <= 1'b0;
                    if (r_ph) begin
                        r_bit <= r_bit - 5'd1;
                    end
                end
            end else begin
                r_done <= 1'b0;
            end
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_q    = r_res;
endmodule

@@ hdl/cpu_utilization_monitor_core.sv @@
// cpu utilization monitor top level: sequencer, per-cpu history ram, sweep totals
// depends on cpum_pkg, cpum_ram, cpum_div and cpu_utilization_monitor_core_assert.svh
//
// One request carries a processor's cumulative idle, kernel, user, deferred and
// interrupt counters. The block reads that processor's previous values from a
// 64-entry history ram (one read-modify-write per in-range request), forms wrapping
// deltas, and returns kernel and user shares in unsigned Q0.16 and a truncated
// load percent. Requests flagged last_of_sweep also return system-wide shares
// built from the sweep sums and the highest core load of the sweep. A single
// bit-serial divider produces every quotient, each quotient bit taking a
// shift-and-subtract step and then a conditional add step; the quotient is
// set directly when the total is zero or the share saturates. Three quotients
// are formed per in-range core request and three more on a last-of-sweep
// request. One request is in flight at a time; the next request is taken once
// the result has been loaded into the output register, which may still be
// waiting on the downstream side. History entries read as zero until first
// written, tracked by one valid flop per processor.
module cpu_utilization_monitor_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [cpum_pkg::IDX_W-1:0]      i_cpu_index,
    input  logic [cpum_pkg::CNT_W-1:0]      i_idle_time,
    input  logic [cpum_pkg::CNT_W-1:0]      i_kernel_time,
    input  logic [cpum_pkg::CNT_W-1:0]      i_user_time,
    input  logic [cpum_pkg::CNT_W-1:0]      i_deferred_time,
    input  logic [cpum_pkg::CNT_W-1:0]      i_interrupt_time,
    input  logic                            i_last_of_sweep,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [cpum_pkg::IDX_W-1:0]      o_echo_index,
    output logic [cpum_pkg::SHARE_W-1:0]    o_core_kernel_share,
    output logic [cpum_pkg::SHARE_W-1:0]    o_core_user_share,
    output logic [cpum_pkg::PCT_W-1:0]      o_core_load_percent,
    output logic                            o_system_valid,
    output logic [cpum_pkg::SHARE_W-1:0]    o_system_kernel_share,
    output logic [cpum_pkg::SHARE_W-1:0]    o_system_user_share,
    output logic [cpum_pkg::PCT_W-1:0]      o_system_load_percent,
    output logic [cpum_pkg::PCT_W-1:0]      o_max_core_percent
);
    import cpum_pkg::*;
    `include "cpu_utilization_monitor_core_assert.svh"

    typedef enum logic [2:0] {
        S_IDLE, S_READ, S_TOTAL, S_START, S_WAIT, S_SYS, S_OUT
    } t_state;

    // quotient being formed: kernel share, user share, load percent
    typedef enum logic [1:0] {
        OP_KERN, OP_USER, OP_LOAD
    } t_op;

    t_state              r_state;
    logic [IDX_W-1:0]    r_idx;
    logic                r_last, r_inr, r_sys;
    logic [CNT_W-1:0]    r_busy, r_user, r_idle;
    logic [CNT_W-1:0]    r_kd, r_ud, r_id, r_t, r_bs;
    logic                r_bc;
    t_op                 r_op;
    logic [CNT_W-1:0]    r_sum_k, r_sum_u, r_sum_i;
    logic [CNT_W-1:0]    r_tot_k, r_tot_u, r_tot_i;
    logic [PCT_W-1:0]    r_max;
    logic [MAX_CPUS-1:0] r_vld;
    logic                r_rd_vld;
    logic [SHARE_W-1:0]  r_ck, r_cu, r_sk, r_su;
    logic [PCT_W-1:0]    r_cp, r_sp;

    logic                in_acc, in_range, ram_we, div_start, div_busy, div_done;
    logic [ENTRY_W-1:0]  ram_rdata, prev;
    logic [SHARE_W-1:0]  div_q;
    logic [CNT_W:0]      bsum;
    t_div_req            div_req;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;
    assign in_range   = (32'(i_cpu_index) < MAX_CPUS);
    assign ram_we     = (r_state == S_READ) && r_inr;
    assign prev       = r_rd_vld ? ram_rdata : '0;
    assign bsum       = {1'b0, r_kd} + {1'b0, r_ud};
    assign div_start  = (r_state == S_START);

    // history entry layout: {busy, user, idle}
    cpum_ram #(.DEPTH(MAX_CPUS), .WIDTH(ENTRY_W), .AW(RAM_AW)) u_hist (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (RAM_AW'(r_idx)),
        .i_wdata ({r_busy, r_user, r_idle}),
        .i_raddr (RAM_AW'(i_cpu_index)),
        .o_rdata (ram_rdata)
    );

    // operand select: kernel share, user share, load percent
    always_comb begin
        div_req.t = r_t;
        case (r_op)
            OP_KERN: begin
                div_req.a = r_kd;  div_req.a_carry = 1'b0;
                div_req.m = MULT_SHARE; div_req.sat = SAT_SHARE;
            end
            OP_USER: begin
                div_req.a = r_ud;  div_req.a_carry = 1'b0;
                div_req.m = MULT_SHARE; div_req.sat = SAT_SHARE;
            end
            default: begin
                div_req.a = r_bs;  div_req.a_carry = r_bc;
                div_req.m = MULT_PCT;   div_req.sat = SAT_PCT;
            end
        endcase
    end

    cpum_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_req   (div_req),
        .o_busy  (div_busy),
        .o_done  (div_done),
        .o_q     (div_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_vld       <= '0;
            r_sum_k     <= '0;
            r_sum_u     <= '0;
            r_sum_i     <= '0;
            r_tot_k     <= '0;
            r_tot_u     <= '0;
            r_tot_i     <= '0;
            r_max       <= '0;
            r_sys       <= 1'b0;
            r_op        <= OP_KERN;
            o_out_valid <= 1'b0;
        end else begin
            // S_OUT reloads the output register itself
            if (o_out_valid && i_out_ready && r_state != S_OUT) begin
                o_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_idx    <= i_cpu_index;
                        r_last   <= i_last_of_sweep;
                        r_inr    <= in_range;
                        r_rd_vld <= r_vld[i_cpu_index];
                        r_idle   <= i_idle_time;
                        r_user   <= i_user_time;
                        // kernel busy = kernel - idle + deferred + interrupt
                        r_busy   <= i_kernel_time - i_idle_time + i_deferred_time
                                    + i_interrupt_time;
                        r_ck     <= '0;
                        r_cu     <= '0;
                        r_cp     <= '0;
                        r_sk     <= '0;
                        r_su     <= '0;
                        r_sp     <= '0;
                        r_sys    <= 1'b0;
                        r_op     <= OP_KERN;
                        r_state  <= S_READ;
                    end
                end
                S_READ: begin
                    // history data arrives this cycle; write back the new values
                    r_kd <= r_busy - prev[3*CNT_W-1:2*CNT_W];
                    r_ud <= r_user - prev[2*CNT_W-1:CNT_W];
                    r_id <= r_idle - prev[CNT_W-1:0];
                    if (r_inr) begin
                        r_vld[r_idx] <= 1'b1;
                        r_sum_k <= r_sum_k + r_busy;
                        r_sum_u <= r_sum_u + r_user;
                        r_sum_i <= r_sum_i + r_idle;
                        r_state <= S_TOTAL;
                    end else begin
                        r_state <= r_last ? S_SYS : S_OUT;
                    end
                end
                S_TOTAL: begin
                    r_t     <= r_kd + r_ud + r_id;
                    r_bs    <= bsum[CNT_W-1:0];
                    r_bc    <= bsum[CNT_W];
                    r_op    <= OP_KERN;
                    r_state <= S_START;
                end
                S_START: begin
                    r_state <= S_WAIT;
                end
                S_WAIT: begin
                    if (div_done) begin
                        case (r_op)
                            OP_KERN: begin
                                if (r_sys) r_sk <= div_q;
                                else       r_ck <= div_q;
                            end
                            OP_USER: begin
                                if (r_sys) r_su <= div_q;
                                else       r_cu <= div_q;
                            end
                            default: begin
                                if (r_sys) begin
                                    r_sp <= div_q[PCT_W-1:0];
                                end else begin
                                    r_cp <= div_q[PCT_W-1:0];
                                    if (div_q[PCT_W-1:0] > r_max) r_max <= div_q[PCT_W-1:0];
                                end
                            end
                        endcase
                        if (r_op == OP_LOAD) begin
                            r_state <= (!r_sys && r_last) ? S_SYS : S_OUT;
                        end else begin
                            r_op    <= (r_op == OP_KERN) ? OP_USER : OP_LOAD;
                            r_state <= S_START;
                        end
                    end
                end
                S_SYS: begin
                    // system deltas from the sweep sums, which already hold this cpu if in range
                    r_kd    <= r_sum_k - r_tot_k;
                    r_ud    <= r_sum_u - r_tot_u;
                    r_id    <= r_sum_i - r_tot_i;
                    r_tot_k <= r_sum_k;
                    r_tot_u <= r_sum_u;
                    r_tot_i <= r_sum_i;
                    r_sys   <= 1'b1;
                    r_state <= S_TOTAL;
                end
                S_OUT: begin
                    // output register may still hold the previous result
                    if (!o_out_valid || i_out_ready) begin
                        o_out_valid           <= 1'b1;
                        o_echo_index          <= r_idx;
                        o_core_kernel_share   <= r_ck;
                        o_core_user_share     <= r_cu;
                        o_core_load_percent   <= r_cp;
                        o_system_valid        <= r_last;
                        o_system_kernel_share <= r_sk;
                        o_system_user_share   <= r_su;
                        o_system_load_percent <= r_sp;
                        o_max_core_percent    <= r_last ? r_max : '0;
                        if (r_last) begin
                            r_sum_k <= '0;
                            r_sum_u <= '0;
                            r_sum_i <= '0;
                            r_max   <= '0;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `CPUM_ASSERT_NEXT(a_busy_after_accept, in_acc, !o_in_ready,
        "input accepted while a request is in flight")
    `CPUM_ASSERT_NOW(a_div_idle_on_start, r_state == S_START, !div_busy,
        "divider started while still busy")
    `CPUM_ASSERT_NOW(a_pct_range, o_out_valid,
        (o_core_load_percent <= PCT_W'(100)) && (o_max_core_percent <= PCT_W'(100)),
        "load percent above 100")
    `CPUM_ASSERT_NOW(a_sys_zero, o_out_valid && !o_system_valid,
        (o_system_kernel_share == '0) && (o_max_core_percent == '0),
        "system fields set on a non-final request")
endmodule
